>>> rtl/lsrod_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// lsrod_pkg
// Shared types, codes and the key table for the load/store register-offset
// instruction decoder.
// ============================================================================
package lsrod_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned KEY_W    = 5;
    localparam int unsigned OP_W     = 4;
    localparam int unsigned CLASS_W  = 3;
    localparam int unsigned REG_W    = 5;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned OPTION_W = 3;
    localparam int unsigned AMOUNT_W = 3;

    localparam logic [KEY_W-1:0]    KEY_PREFETCH   = 5'b11010;
    localparam logic [OPTION_W-1:0] OPTION_LSL     = 3'b011;
    localparam logic [AMOUNT_W-1:0] PREFETCH_SCALE = 3'd3;
    localparam logic [1:0]          RT_RANGE_HI    = 2'b11;

    localparam logic [OP_W-1:0] OP_STRB  = 4'd0;
    localparam logic [OP_W-1:0] OP_LDRB  = 4'd1;
    localparam logic [OP_W-1:0] OP_LDRSB = 4'd2;
    localparam logic [OP_W-1:0] OP_STR   = 4'd3;
    localparam logic [OP_W-1:0] OP_LDR   = 4'd4;
    localparam logic [OP_W-1:0] OP_STRH  = 4'd5;
    localparam logic [OP_W-1:0] OP_LDRH  = 4'd6;
    localparam logic [OP_W-1:0] OP_LDRSH = 4'd7;
    localparam logic [OP_W-1:0] OP_LDRSW = 4'd8;
    localparam logic [OP_W-1:0] OP_PRFM  = 4'd9;
    localparam logic [OP_W-1:0] OP_RPRFM = 4'd10;

    localparam logic [CLASS_W-1:0] CLS_W   = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_X   = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_B   = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_H   = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_S   = 3'd4;
    localparam logic [CLASS_W-1:0] CLS_D   = 3'd5;
    localparam logic [CLASS_W-1:0] CLS_Q   = 3'd6;
    localparam logic [CLASS_W-1:0] CLS_PRF = 3'd7;

    localparam logic [KIND_W-1:0] MOD_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] MOD_EXTEND = 2'd1;
    localparam logic [KIND_W-1:0] MOD_SHIFT  = 2'd2;

    typedef struct packed {
        logic                valid;
        logic [OP_W-1:0]     op;
        logic [CLASS_W-1:0]  cls;
        logic [AMOUNT_W-1:0] scale;
    } key_entry_t;

    typedef struct packed {
        logic                decoded_ok;
        logic [OP_W-1:0]     operation;
        logic [CLASS_W-1:0]  transfer_class;
        logic [REG_W-1:0]    transfer_reg;
        logic [REG_W-1:0]    base_reg;
        logic [REG_W-1:0]    index_reg;
        logic                index_is_wide;
        logic [KIND_W-1:0]   modifier_kind;
        logic [OPTION_W-1:0] extend_option;
        logic [AMOUNT_W-1:0] modifier_amount;
    } result_t;

    function automatic key_entry_t key_lookup(input logic [KEY_W-1:0] key);
        key_entry_t e;
        e = '0;
        unique case (key)
            5'd0:    e = '{1'b1, OP_STRB,  CLS_W, 3'd0};
            5'd1:    e = '{1'b1, OP_LDRB,  CLS_W, 3'd0};
            5'd2:    e = '{1'b1, OP_LDRSB, CLS_X, 3'd0};
            5'd3:    e = '{1'b1, OP_LDRSB, CLS_W, 3'd0};
            5'd4:    e = '{1'b1, OP_STR,   CLS_B, 3'd0};
            5'd5:    e = '{1'b1, OP_LDR,   CLS_B, 3'd0};
            5'd6:    e = '{1'b1, OP_STR,   CLS_Q, 3'd4};
            5'd7:    e = '{1'b1, OP_LDR,   CLS_Q, 3'd4};
            5'd8:    e = '{1'b1, OP_STRH,  CLS_W, 3'd1};
            5'd9:    e = '{1'b1, OP_LDRH,  CLS_W, 3'd1};
            5'd10:   e = '{1'b1, OP_LDRSH, CLS_X, 3'd1};
            5'd11:   e = '{1'b1, OP_LDRSH, CLS_W, 3'd1};
            5'd12:   e = '{1'b1, OP_STR,   CLS_H, 3'd1};
            5'd13:   e = '{1'b1, OP_LDR,   CLS_H, 3'd1};
            5'd16:   e = '{1'b1, OP_STR,   CLS_W, 3'd2};
            5'd17:   e = '{1'b1, OP_LDR,   CLS_W, 3'd2};
            5'd18:   e = '{1'b1, OP_LDRSW, CLS_X, 3'd2};
            5'd20:   e = '{1'b1, OP_STR,   CLS_S, 3'd2};
            5'd21:   e = '{1'b1, OP_LDR,   CLS_S, 3'd2};
            5'd24:   e = '{1'b1, OP_STR,   CLS_X, 3'd3};
            5'd25:   e = '{1'b1, OP_LDR,   CLS_X, 3'd3};
            5'd26:   e = '{1'b1, OP_PRFM,  CLS_PRF, PREFETCH_SCALE};
            5'd28:   e = '{1'b1, OP_STR,   CLS_D, 3'd3};
            5'd29:   e = '{1'b1, OP_LDR,   CLS_D, 3'd3};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

>>> rtl/load_store_register_offset_decoder_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// load_store_register_offset_decoder_unit
// Decodes one load/store register-offset instruction word into operation,
// register class, operand registers and the address modifier.
// ============================================================================
// Pipeline: start loads the input register, the decode result is registered
// behind it, and the result register's valid flag drives the done strobe.
// Throughput: one word per cycle; busy stays low, as the stages are pipelined.
// Reset: rst_n clears the stage valid flags; no result is shown until a new
// start transfer. The receiver cannot stall, so no result ever waits.
module load_store_register_offset_decoder_unit
    import lsrod_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [WORD_W-1:0]   instruction_word,
    output logic                done,
    output logic                decoded_ok,
    output logic [OP_W-1:0]     operation,
    output logic [CLASS_W-1:0]  transfer_class,
    output logic [REG_W-1:0]    transfer_reg,
    output logic [REG_W-1:0]    base_reg,
    output logic [REG_W-1:0]    index_reg,
    output logic                index_is_wide,
    output logic [KIND_W-1:0]   modifier_kind,
    output logic [OPTION_W-1:0] extend_option,
    output logic [AMOUNT_W-1:0] modifier_amount
);

    logic              in_valid_reg;
    logic [WORD_W-1:0] word_reg;
    logic              out_valid_reg;
    result_t           result_reg;
    result_t           result_next;

    logic [KEY_W-1:0]    key;
    key_entry_t          entry;
    logic [OPTION_W-1:0] option;
    logic                sbit;
    logic [REG_W-1:0]    rt;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= start && !busy;
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            word_reg <= instruction_word;
        end
        if (in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign key    = {word_reg[31:30], word_reg[26], word_reg[23:22]};
    assign entry  = key_lookup(key);
    assign option = word_reg[15:13];
    assign sbit   = word_reg[12];
    assign rt     = word_reg[4:0];

    always_comb
    begin
        result_next = '0;
        if (entry.valid && option[1])
        begin
            result_next.decoded_ok     = 1'b1;
            result_next.operation      = entry.op;
            result_next.transfer_class = entry.cls;
            result_next.transfer_reg   = rt;
            result_next.base_reg       = word_reg[9:5];
            result_next.index_reg      = word_reg[20:16];
            result_next.index_is_wide  = option[0];
            if (key == KEY_PREFETCH && rt[4:3] == RT_RANGE_HI)
            begin
                result_next.operation     = OP_RPRFM;
                result_next.index_is_wide = 1'b1;
            end
            else if (option == OPTION_LSL)
            begin
                if (sbit)
                begin
                    result_next.modifier_kind   = MOD_SHIFT;
                    result_next.modifier_amount = entry.scale;
                end
            end
            else
            begin
                result_next.modifier_kind   = MOD_EXTEND;
                result_next.extend_option   = option;
                result_next.modifier_amount = sbit ? entry.scale : '0;
            end
        end
    end

    assign done            = out_valid_reg;
    assign decoded_ok      = result_reg.decoded_ok;
    assign operation       = result_reg.operation;
    assign transfer_class  = result_reg.transfer_class;
    assign transfer_reg    = result_reg.transfer_reg;
    assign base_reg        = result_reg.base_reg;
    assign index_reg       = result_reg.index_reg;
    assign index_is_wide   = result_reg.index_is_wide;
    assign modifier_kind   = result_reg.modifier_kind;
    assign extend_option   = result_reg.extend_option;
    assign modifier_amount = result_reg.modifier_amount;

endmodule

>>> rtl/lsrod_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// lsrod_checker
// Port-level checks on the decoder: strobe timing and result consistency.
// ============================================================================
module lsrod_checker
    import lsrod_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic                decoded_ok,
    input logic [OP_W-1:0]     operation,
    input logic [CLASS_W-1:0]  transfer_class,
    input logic [REG_W-1:0]    transfer_reg,
    input logic [REG_W-1:0]    base_reg,
    input logic [REG_W-1:0]    index_reg,
    input logic                index_is_wide,
    input logic [KIND_W-1:0]   modifier_kind,
    input logic [OPTION_W-1:0] extend_option,
    input logic [AMOUNT_W-1:0] modifier_amount
);

    a_done_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("transfer not followed by done after two cycles");

    a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !decoded_ok) |-> (operation == '0 && transfer_class == '0 &&
        transfer_reg == '0 && base_reg == '0 && index_reg == '0 &&
        !index_is_wide && modifier_kind == '0 && extend_option == '0 &&
        modifier_amount == '0))
        else $error("undefined encoding with nonzero fields");

    a_prefetch_class: assert property (@(posedge clk) disable iff (!rst_n)
        (done && decoded_ok) |-> ((transfer_class == CLS_PRF) ==
        (operation == OP_PRFM || operation == OP_RPRFM)))
        else $error("prefetch class and operation disagree");

    a_rprfm_form: assert property (@(posedge clk) disable iff (!rst_n)
        (done && decoded_ok && operation == OP_RPRFM) |->
        (index_is_wide && modifier_kind == MOD_NONE && transfer_reg[4:3] == 2'b11))
        else $error("malformed range prefetch result");

    a_extend_option: assert property (@(posedge clk) disable iff (!rst_n)
        (done && decoded_ok) |-> ((modifier_kind == MOD_EXTEND) ==
        (extend_option != '0)) && (index_is_wide || extend_option[0] == 1'b0))
        else $error("extend option inconsistent with modifier");

endmodule

bind load_store_register_offset_decoder_unit lsrod_checker u_lsrod_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .decoded_ok      (decoded_ok),
    .operation       (operation),
    .transfer_class  (transfer_class),
    .transfer_reg    (transfer_reg),
    .base_reg        (base_reg),
    .index_reg       (index_reg),
    .index_is_wide   (index_is_wide),
    .modifier_kind   (modifier_kind),
    .extend_option   (extend_option),
    .modifier_amount (modifier_amount)
);
